// File: sv/bsp_pkg.sv
// Shared types, codes and constants for the bencode stream parser.
package bsp_pkg;

  localparam int unsigned MAX_DEPTH_DEF = 32;
  localparam int unsigned LEN_BITS_DEF  = 32;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_INTEGER   = 3'd1,
    EV_STR_HEAD  = 3'd2,
    EV_STR_BYTE  = 3'd3,
    EV_LIST_OPEN = 3'd4,
    EV_DICT_OPEN = 3'd5,
    EV_CLOSE     = 3'd6
  } event_t;

  typedef enum logic [3:0] {
    ERR_OK        = 4'd0,
    ERR_BAD_VALUE = 4'd1,
    ERR_BAD_INT   = 4'd2,
    ERR_INT_OVF   = 4'd3,
    ERR_BAD_LEN   = 4'd4,
    ERR_NO_COLON  = 4'd5,
    ERR_LEN_BIG   = 4'd6,
    ERR_DEPTH     = 4'd7,
    ERR_TRUNC     = 4'd8
  } err_t;

  typedef enum logic [7:0] {
    M_EXPECT     = 8'b0000_0001,
    M_INT_START  = 8'b0000_0010,
    M_INT_NEG    = 8'b0000_0100,
    M_INT_DIGITS = 8'b0000_1000,
    M_INT_ZERO   = 8'b0001_0000,
    M_LEN        = 8'b0010_0000,
    M_BODY       = 8'b0100_0000,
    M_DONE       = 8'b1000_0000
  } mode_t;

  typedef enum logic [1:0] {
    K_LIST     = 2'd0,
    K_DICT_KEY = 2'd1,
    K_DICT_VAL = 2'd2
  } kind_t;

  typedef struct packed {
    event_t      evt;
    logic [63:0] payload;
    logic [5:0]  nest;
    logic        is_key;
    logic        last;
    logic        done;
    err_t        err;
  } result_t;

endpackage

// File: sv/bencode_stream_parser_unit.sv
// Top level of the bencode stream parser: input register, decode step, result register.
//
//   channel  ports                                    role
//   in_      valid/ready, data_byte, message_start,   one message byte per word
//            end_of_input
//   out_     valid/ready, event_res, payload,          one event per input word
//            nest_level, is_key, last_string_byte,
//            message_done, error_code
//
// Each word sits in the input register, where the decode step reads
// the parse state and the top of the container stack, and then lands in the result
// register; one word is taken every cycle while the output is not stalled.
// Reset clears the parse state; the stack memory is not cleared.
// A stalled out_ready holds the result and the input word, and in_ready drops while the input register is full.
module bencode_stream_parser_unit #(
  parameter int unsigned MAX_DEPTH = bsp_pkg::MAX_DEPTH_DEF,
  parameter int unsigned LEN_BITS  = bsp_pkg::LEN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_message_start,
  input  logic               in_end_of_input,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_event_res,
  output logic signed [63:0] out_payload,
  output logic [5:0]         out_nest_level,
  output logic               out_is_key,
  output logic               out_last_string_byte,
  output logic               out_message_done,
  output logic [3:0]         out_error_code
);
  import bsp_pkg::*;

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       start_r;
  logic       eoi_r;
  logic       step;
  logic       out_v_r;
  result_t    res, res_r;

  assign step     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (step) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_data_byte;
      start_r <= in_message_start;
      eoi_r   <= in_end_of_input;
    end
    if (step) res_r <= res;
  end

  bsp_core #(
    .MAX_DEPTH(MAX_DEPTH),
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .data_byte    (byte_r),
    .message_start(start_r),
    .end_of_input (eoi_r),
    .res          (res)
  );

  assign out_valid            = out_v_r;
  assign out_event_res        = res_r.evt;
  assign out_payload          = res_r.payload;
  assign out_nest_level       = res_r.nest;
  assign out_is_key           = res_r.is_key;
  assign out_last_string_byte = res_r.last;
  assign out_message_done     = res_r.done;
  assign out_error_code       = res_r.err;

endmodule

// File: sv/bsp_core.sv
// Parse state, container stack and per-byte decode step.
module bsp_core #(
  parameter int unsigned MAX_DEPTH = bsp_pkg::MAX_DEPTH_DEF,
  parameter int unsigned LEN_BITS  = bsp_pkg::LEN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             message_start,
  input  logic             end_of_input,
  output bsp_pkg::result_t res
);
  import bsp_pkg::*;

  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LEN_BITS);

  mode_t                mode_r, mode_nxt, mode_cur;
  logic [63:0]          acc_r, acc_nxt, acc_cur;
  logic                 neg_r, neg_nxt, neg_cur;
  logic [LEN_BITS-1:0]  rem_r, rem_nxt, rem_cur;
  logic [LVL_W-1:0]     level_r, level_nxt, level_cur, level_fwd;
  err_t                 err_r, err_nxt, err_cur;
  kind_t                top_r, top_nxt, top_kind;

  kind_t                stack_mem [MAX_DEPTH];
  kind_t                rd_r;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;

  logic                 is_digit;
  logic [3:0]           dig;
  logic [67:0]          prod;
  logic [67:0]          int_lim;
  logic                 finish, push;
  logic                 want_key;
  event_t               evt;
  logic [63:0]          pay;
  logic                 key, last;

  function automatic kind_t flip_kind(input kind_t k);
    kind_t r;
    r = k;
    if (k == K_DICT_KEY) r = K_DICT_VAL;
    else if (k == K_DICT_VAL) r = K_DICT_KEY;
    return r;
  endfunction

  always_comb begin
    mode_cur  = message_start ? M_EXPECT : mode_r;
    acc_cur   = message_start ? '0 : acc_r;
    neg_cur   = message_start ? 1'b0 : neg_r;
    rem_cur   = message_start ? '0 : rem_r;
    level_cur = message_start ? '0 : level_r;
    err_cur   = message_start ? ERR_OK : err_r;

    is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    dig      = is_digit ? 4'(data_byte - CH_ZERO) : 4'd0;
    // times ten as two shifts and one add
    prod     = ({4'b0, acc_cur} << 3) + ({4'b0, acc_cur} << 1) + 68'(dig);
    int_lim  = neg_cur ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
    top_kind = (level_cur == '0) ? K_LIST : top_r;
    want_key = (level_cur != '0) && (top_kind == K_DICT_KEY);

    mode_nxt  = mode_cur;
    acc_nxt   = acc_cur;
    neg_nxt   = neg_cur;
    rem_nxt   = rem_cur;
    level_nxt = level_cur;
    err_nxt   = err_cur;
    top_nxt   = top_r;
    finish    = 1'b0;
    push      = 1'b0;
    evt       = EV_NONE;
    pay       = '0;
    key       = 1'b0;
    last      = 1'b0;

    if (err_cur != ERR_OK) begin
      // hold everything until the next message
    end else if (end_of_input) begin
      if (mode_cur != M_DONE) err_nxt = ERR_TRUNC;
    end else begin
      unique case (mode_cur)
        M_EXPECT: begin
          priority if (data_byte == CH_E && level_cur != '0 && top_kind != K_DICT_VAL) begin
            level_nxt = level_cur - LVL_W'(1);
            top_nxt   = rd_r;
            evt       = EV_CLOSE;
            finish    = 1'b1;
          end else if (is_digit) begin
            acc_nxt  = {60'd0, dig};
            mode_nxt = M_LEN;
          end else if (want_key) begin
            err_nxt = ERR_BAD_LEN;
          end else if (data_byte == CH_I) begin
            acc_nxt  = '0;
            neg_nxt  = 1'b0;
            mode_nxt = M_INT_START;
          end else if (data_byte == CH_L || data_byte == CH_D) begin
            if (level_cur >= LVL_W'(MAX_DEPTH)) begin
              err_nxt = ERR_DEPTH;
            end else begin
              push      = 1'b1;
              top_nxt   = (data_byte == CH_L) ? K_LIST : K_DICT_KEY;
              level_nxt = level_cur + LVL_W'(1);
              evt       = (data_byte == CH_L) ? EV_LIST_OPEN : EV_DICT_OPEN;
            end
          end else begin
            err_nxt = ERR_BAD_VALUE;
          end
        end
        M_INT_START: begin
          priority if (data_byte == CH_MINUS) begin
            neg_nxt  = 1'b1;
            mode_nxt = M_INT_NEG;
          end else if (data_byte == CH_ZERO) begin
            acc_nxt  = '0;
            mode_nxt = M_INT_ZERO;
          end else if (is_digit) begin
            acc_nxt  = {60'd0, dig};
            mode_nxt = M_INT_DIGITS;
          end else begin
            err_nxt = ERR_BAD_INT;
          end
        end
        M_INT_NEG: begin
          if (is_digit && dig != 4'd0) begin
            acc_nxt  = {60'd0, dig};
            mode_nxt = M_INT_DIGITS;
          end else begin
            err_nxt = ERR_BAD_INT;
          end
        end
        M_INT_DIGITS, M_INT_ZERO: begin
          priority if (data_byte == CH_E) begin
            evt    = EV_INTEGER;
            pay    = neg_cur ? (64'd0 - acc_cur) : acc_cur;
            finish = 1'b1;
          end else if (is_digit && mode_cur == M_INT_DIGITS) begin
            if (prod > int_lim) err_nxt = ERR_INT_OVF;
            else acc_nxt = prod[63:0];
          end else begin
            err_nxt = ERR_BAD_INT;
          end
        end
        M_LEN: begin
          priority if (is_digit) begin
            if (prod > {4'b0, LEN_MAX}) err_nxt = ERR_LEN_BIG;
            else acc_nxt = prod[63:0];
          end else if (data_byte == CH_COLON) begin
            evt = EV_STR_HEAD;
            pay = acc_cur;
            key = want_key;
            if (acc_cur == '0) begin
              last   = 1'b1;
              finish = 1'b1;
            end else begin
              rem_nxt  = acc_cur[LEN_BITS-1:0];
              mode_nxt = M_BODY;
            end
          end else begin
            err_nxt = ERR_NO_COLON;
          end
        end
        M_BODY: begin
          evt = EV_STR_BYTE;
          pay = {56'd0, data_byte};
          key = want_key;
          if (rem_cur != '0) rem_nxt = rem_cur - LEN_BITS'(1);
          if (rem_nxt == '0) begin
            last   = 1'b1;
            finish = 1'b1;
          end
        end
        M_DONE: begin
          // drop trailing bytes
        end
        default: begin
        end
      endcase
    end

    if (finish) begin
      if (level_nxt == '0) begin
        mode_nxt = M_DONE;
      end else begin
        mode_nxt = M_EXPECT;
        top_nxt  = flip_kind(top_nxt);
      end
    end

    if (err_nxt != ERR_OK) begin
      evt  = EV_NONE;
      pay  = '0;
      key  = 1'b0;
      last = 1'b0;
    end

    res.evt     = evt;
    res.payload = pay;
    res.nest    = 6'(level_nxt);
    res.is_key  = key;
    res.last    = last;
    res.done    = (mode_nxt == M_DONE);
    res.err     = err_nxt;
  end

  // The top lives in top_r; the stack memory holds the entries beneath it.
  assign wr_en     = step && push && (level_cur != '0);
  assign wr_addr   = AW'(level_cur - LVL_W'(1));
  assign level_fwd = step ? level_nxt : level_r;
  assign rd_addr   = (level_fwd >= LVL_W'(2)) ? AW'(level_fwd - LVL_W'(2)) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[wr_addr] <= top_r;
    // keep the entry beneath the top ready for a close
    rd_r <= (wr_en && wr_addr == rd_addr) ? top_r : stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_EXPECT;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      rem_r   <= '0;
      level_r <= '0;
      err_r   <= ERR_OK;
      top_r   <= K_LIST;
    end else if (step) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      rem_r   <= rem_nxt;
      level_r <= level_nxt;
      err_r   <= err_nxt;
      top_r   <= top_nxt;
    end
  end

endmodule

// File: sv/bsp_checker.sv
// Port-level checks for the bencode stream parser, bound to the top level.
module bsp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_event_res,
  input logic signed [63:0] out_payload,
  input logic [5:0]         out_nest_level,
  input logic               out_is_key,
  input logic               out_last_string_byte,
  input logic               out_message_done,
  input logic [3:0]         out_error_code
);
  import bsp_pkg::*;

  // a stalled result word holds its event, payload and error code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)
      && $stable(out_event_res) && $stable(out_error_code))
    else $error("result word changed while stalled");

  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_OK |->
      out_event_res == EV_NONE && out_payload == 64'sd0
      && !out_is_key && !out_last_string_byte)
    else $error("event raised while an error is set");

  a_str_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_STR_HEAD && out_event_res != EV_STR_BYTE |->
      !out_is_key && !out_last_string_byte)
    else $error("string flags outside a string event");

  a_done_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_nest_level == 6'd0)
    else $error("message done while nested");

endmodule

bind bencode_stream_parser_unit bsp_checker u_bsp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_event_res       (out_event_res),
  .out_payload         (out_payload),
  .out_nest_level      (out_nest_level),
  .out_is_key          (out_is_key),
  .out_last_string_byte(out_last_string_byte),
  .out_message_done    (out_message_done),
  .out_error_code      (out_error_code)
);
